// File: rtl/bac_pkg.sv
// Shared types, widths and helpers for the block address extent coalescer.
// Used by bac_core, bac_out_fifo and block_address_extent_coalescer.
package bac_pkg;

  localparam int unsigned AddrW      = 32;
  localparam int unsigned LenW       = 18;
  localparam int unsigned CntW       = 16;
  localparam int unsigned GroupShift = 9;

  localparam logic [AddrW-1:0] HoleAddr = '1;
  localparam logic [LenW-1:0]  RunLimit = LenW'(131072);
  localparam logic [CntW-1:0]  CntMax   = '1;

  // Output word layout: start, length, number, mapped, padded to whole bytes.
  localparam int unsigned FieldsW = AddrW + LenW + CntW + CntW;
  localparam int unsigned TdataW  = ((FieldsW + 7) / 8) * 8;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CountW    = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic             ext_valid;
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  length;
    logic [CntW-1:0]  number;
    logic [CntW-1:0]  mapped;
    logic             run_end;
  } result_t;

  // Up to two result words produced by one accepted address.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/bac_core.sv
// Extent merge logic and run state for the block address extent coalescer.
// Depends on bac_pkg; feeds bac_out_fifo with up to two result words per address.
module bac_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bac_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      accept_i,
  input  logic [bac_pkg::AddrW-1:0] addr_i,
  input  logic                      last_i,
  output bac_pkg::push_t            push_o
);
  import bac_pkg::*;

  logic [LenW-1:0]  max_len_q;
  logic [AddrW-1:0] start_q, start_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             open_q, open_d;
  logic [CntW-1:0]  emitted_q, emitted_d;
  logic [CntW-1:0]  mapped_q, mapped_d;

  logic [LenW-1:0]  limit;
  logic [AddrW:0]   next_addr;
  logic             hole, same_group, extend, close_a, close_b;
  logic [CntW-1:0]  num_a, num_b, emitted_mid;
  result_t          res_a, res_b, res_d;

  always_comb begin
    limit      = (max_len_q > RunLimit) ? RunLimit : max_len_q;
    hole       = (addr_i == HoleAddr);
    next_addr  = {1'b0, start_q} + {{(AddrW + 1 - LenW){1'b0}}, len_q};
    same_group = (start_q[AddrW-1:GroupShift] == addr_i[AddrW-1:GroupShift]);
    extend     = open_q && !hole && (next_addr == {1'b0, addr_i}) && same_group
                 && (len_q < limit);
    // Any open extent that is not extended by this address is closed.
    close_a    = open_q && !extend;

    mapped_d   = hole ? mapped_q : sat_inc(mapped_q);
    start_d    = (hole || extend) ? start_q : addr_i;
    len_d      = extend ? len_q + 1'b1 : (hole ? len_q : LenW'(1));
    open_d     = !hole;
    close_b    = last_i && open_d;

    num_a       = sat_inc(emitted_q);
    emitted_mid = close_a ? num_a : emitted_q;
    num_b       = sat_inc(emitted_mid);
    emitted_d   = close_b ? num_b : emitted_mid;

    res_a = '{ext_valid: 1'b1, start: start_q, length: len_q, number: num_a,
              mapped: mapped_d, run_end: last_i && !close_b};
    res_b = '{ext_valid: 1'b1, start: start_d, length: len_d, number: num_b,
              mapped: mapped_d, run_end: 1'b1};
    res_d = '{ext_valid: 1'b0, start: '0, length: '0, number: emitted_mid,
              mapped: mapped_d, run_end: 1'b1};

    push_o.second = res_b;
    if (close_a) begin
      push_o.first = res_a;
      push_o.num   = close_b ? 2'd2 : 2'd1;
    end else if (close_b) begin
      push_o.first = res_b;
      push_o.num   = 2'd1;
    end else begin
      push_o.first = res_d;
      push_o.num   = last_i ? 2'd1 : 2'd0;
    end
    if (!accept_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= RunLimit;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      len_q     <= '0;
      open_q    <= 1'b0;
      emitted_q <= '0;
      mapped_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        // The sequence ends here; the next one starts from a clean state.
        start_q   <= '0;
        len_q     <= '0;
        open_q    <= 1'b0;
        emitted_q <= '0;
        mapped_q  <= '0;
      end else begin
        start_q   <= start_d;
        len_q     <= len_d;
        open_q    <= open_d;
        emitted_q <= emitted_d;
        mapped_q  <= mapped_d;
      end
    end
  end

endmodule

// File: rtl/bac_out_fifo.sv
// Small result queue that takes up to two words a cycle and releases one.
// Depends on bac_pkg for the result word type and the queue depth.
module bac_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bac_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output bac_pkg::result_t data_o
);
  import bac_pkg::*;

  result_t           mem_q [FifoDepth];
  logic [PtrW-1:0]   wr_q, rd_q, wr_next;
  logic [CountW-1:0] count_q, count_d;
  logic              pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  // Two free words are needed, since one address can close two extents.
  assign room_o  = (count_q <= CountW'(FifoDepth - 2));
  assign data_o  = mem_q[rd_q];
  assign wr_next = wr_q + 1'b1;
  assign count_d = count_q + CountW'(push_i.num) - CountW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_i.num);
      rd_q    <= rd_q + PtrW'(pop);
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/block_address_extent_coalescer.sv
// Top level of the block address extent coalescer: stream ports and packing.
// Depends on bac_pkg, bac_core and bac_out_fifo.
//
// Takes one block address word per cycle and merges consecutive addresses
// into extents of start and length; all-ones marks an unmapped hole. An
// address extends the open extent only if it follows it directly, lies in
// the same 512-block group and the extent is still below max_run_length
// (values above 131072 act as 131072, zero acts as one). When the queue is
// empty, a result word appears on the output in the cycle after the address
// that caused it. Results leave through a four-word queue; an address is
// taken whenever at least two queue words are free, so the input runs at
// one word per cycle as long as the output keeps up, and an address that
// closes two extents pushes two words. The word marked tlast flushes
// the open extent and ends the run; it always yields at least one result,
// the last of which carries tlast.
module block_address_extent_coalescer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bac_pkg::LenW-1:0]   cfg_wdata_i,   // max_run_length
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [bac_pkg::AddrW-1:0]  s_axis_tdata_i, // block_address
  input  logic                       s_axis_tlast_i, // final_entry
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // extent_start, extent_length, extent_number, mapped_blocks, zero padding
  output logic [bac_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic                       m_axis_tuser_o, // extent_valid
  output logic                       m_axis_tlast_o  // run_end
);
  import bac_pkg::*;

  push_t   push;
  result_t head;
  logic    accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  bac_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .addr_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .push_o      (push)
  );

  bac_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  assign m_axis_tdata_o = {{(TdataW - FieldsW){1'b0}}, head.mapped, head.number,
                           head.length, head.start};
  assign m_axis_tuser_o = head.ext_valid;
  assign m_axis_tlast_o = head.run_end;

endmodule
